// File: hw/rtl/mssp_pkg.sv
package mssp_pkg;

    localparam int NUM_STACKS = 8;
    localparam int POOL_SIZE  = 64;
    localparam int DATA_W     = 32;
    localparam int SEL_W      = 3;

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LNK_W = $clog2(POOL_SIZE + 1);
    localparam int STK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(POOL_SIZE);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// File: hw/rtl/mssp_ctrl.sv
module mssp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output mssp_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_exec;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_exec     = (r_state == S_EXEC) && (!r_out_vld || i_m_tready);
    assign o_cmd.load = i_s_tvalid && o_s_tready;
    assign o_cmd.exec = w_exec;
    assign o_m_tvalid = r_out_vld;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_exec) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_exec) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// File: hw/rtl/mssp_dp.sv
module mssp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mssp_pkg::t_cmd              i_cmd,
    input  logic                        i_op,
    input  logic [mssp_pkg::SEL_W-1:0]  i_sel,
    input  logic [mssp_pkg::DATA_W-1:0] i_val,
    output logic                        o_ok,
    output logic [mssp_pkg::DATA_W-1:0] o_data
);

    logic [mssp_pkg::LNK_W-1:0]  r_top [mssp_pkg::NUM_STACKS];
    logic [mssp_pkg::LNK_W-1:0]  r_free;
    logic [mssp_pkg::POOL_SIZE-1:0] r_link_vld;
    logic [mssp_pkg::LNK_W-1:0]  r_link_mem [mssp_pkg::POOL_SIZE];
    logic [mssp_pkg::DATA_W-1:0] r_data_mem [mssp_pkg::POOL_SIZE];
    logic [mssp_pkg::LNK_W-1:0]  r_link_rd;
    logic [mssp_pkg::DATA_W-1:0] r_data_rd;

    logic                        r_op;
    logic [mssp_pkg::STK_W-1:0]  r_stk;
    logic [mssp_pkg::DATA_W-1:0] r_val;
    logic [mssp_pkg::IDX_W-1:0]  r_idx;
    logic [mssp_pkg::LNK_W-1:0]  r_top_rd;
    logic                        r_fail;
    logic                        r_ok;
    logic [mssp_pkg::DATA_W-1:0] r_out;

    logic                        w_sel_ok;
    logic [mssp_pkg::STK_W-1:0]  w_stk;
    logic [mssp_pkg::LNK_W-1:0]  w_top;
    logic [mssp_pkg::LNK_W-1:0]  w_addr;
    logic [mssp_pkg::IDX_W-1:0]  w_a;
    logic                        w_fail;
    logic                        w_push;
    logic                        w_wr;

    assign w_sel_ok = 32'(i_sel) < mssp_pkg::NUM_STACKS;
    assign w_stk    = mssp_pkg::STK_W'(i_sel);
    assign w_top    = w_sel_ok ? r_top[w_stk] : mssp_pkg::LINK_NULL;
    assign w_addr   = (i_op == mssp_pkg::OP_POP) ? w_top : r_free;
    assign w_a      = w_addr[mssp_pkg::IDX_W-1:0];
    assign w_fail   = !w_sel_ok || (32'(w_addr) >= mssp_pkg::POOL_SIZE);
    assign w_push   = (r_op == mssp_pkg::OP_PUSH);
    assign w_wr     = i_cmd.exec && !r_fail;

    // operand capture and first read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_stk     <= w_stk;
            r_val     <= i_val;
            r_idx     <= w_a;
            r_top_rd  <= w_top;
            r_fail    <= w_fail;
            r_link_rd <= r_link_vld[w_a] ? r_link_mem[w_a]
                                         : mssp_pkg::LNK_W'(w_a) + 1'b1;
            r_data_rd <= r_data_mem[w_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_link_mem[r_idx] <= w_push ? r_top_rd : r_free;
            if (w_push) begin
                r_data_mem[r_idx] <= r_val;
            end
        end
    end

    // list heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mssp_pkg::NUM_STACKS; i++) begin
                r_top[i] <= mssp_pkg::LINK_NULL;
            end
            r_free     <= '0;
            r_link_vld <= '0;
        end else if (w_wr) begin
            r_top[r_stk]      <= w_push ? mssp_pkg::LNK_W'(r_idx) : r_link_rd;
            r_free            <= w_push ? r_link_rd : mssp_pkg::LNK_W'(r_idx);
            r_link_vld[r_idx] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok <= !r_fail;
            if (w_push) begin
                r_out <= '0;
            end else if (r_fail) begin
                r_out <= '1;
            end else begin
                r_out <= r_data_rd;
            end
        end
    end

    assign o_ok   = r_ok;
    assign o_data = r_out;

endmodule

// File: hw/rtl/multi_stack_shared_pool.sv
// channel | dir | tdata                 | tuser
// s_axis  | in  | [31:0] value          | [0] operation, [3:1] stack_select
// m_axis  | out | [31:0] popped_value   | [0] success
//
// the link and data stores are read in the accept cycle and written back with
// the result in the exec state, once the output register is free.
// one item is in work at a time; a result waiting on m_axis holds the next
// item in its exec state.
// reset is synchronous active low; it empties all stacks and rebuilds the free
// list at once, with no clearing pass.
module multi_stack_shared_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // value
    input  logic [3:0]  i_s_tuser,  // operation, stack_select
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // popped_value
    output logic [0:0]  o_m_tuser   // success
);

    mssp_pkg::t_cmd w_cmd;

    mssp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    mssp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_op    (i_s_tuser[0]),
        .i_sel   (i_s_tuser[3:1]),
        .i_val   (i_s_tdata),
        .o_ok    (o_m_tuser[0]),
        .o_data  (o_m_tdata)
    );

endmodule

// File: sim/tb_top.sv
module tb_top;
    import mssp_pkg::*;

    typedef struct packed {
        t_op              op;
        logic [SEL_W-1:0] sel;
        logic [DATA_W-1:0] val;
    } stack_op_t;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] word;
    } stack_result_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [31:0] s_tdata    = '0;
    logic [3:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    stack_op_t     pending_ops[$];
    stack_result_t awaited_results[$];
    int            total_ops   = 0;
    int            n_accepted  = 0;
    int            fail_count  = 0;
    int            idle_pct    = 12;
    int            s_hold      = 0;
    int            m_hold      = 0;

    // own copy of the pool: entry data, entry links, stack heads, free-list head
    logic [DATA_W-1:0] pool_data[POOL_SIZE];
    logic [LNK_W-1:0]  pool_link[POOL_SIZE];
    logic [LNK_W-1:0]  head_of[NUM_STACKS];
    logic [LNK_W-1:0]  free_ptr;

    multi_stack_shared_pool i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic stack_result_t run_stack_op(t_op op, logic [SEL_W-1:0] sel,
                                                   logic [DATA_W-1:0] val);
        stack_result_t    r;
        logic [LNK_W-1:0] idx;
        r.ok   = 1'b0;
        r.word = '0;
        if (op == OP_PUSH) begin
            if (int'(sel) < NUM_STACKS && free_ptr < LINK_NULL) begin
                idx            = free_ptr;
                free_ptr       = pool_link[idx];
                pool_data[idx] = val;
                pool_link[idx] = head_of[sel];
                head_of[sel]   = idx;
                r.ok           = 1'b1;
            end
        end else begin
            if (int'(sel) < NUM_STACKS && head_of[sel] < LINK_NULL) begin
                idx            = head_of[sel];
                head_of[sel]   = pool_link[idx];
                pool_link[idx] = free_ptr;
                free_ptr       = idx;
                r.ok           = 1'b1;
                r.word         = pool_data[idx];
            end else begin
                r.word = '1;
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h7fff_ffff;
            default: return 32'h8000_0000;
        endcase
    endfunction

    task automatic queue_op(t_op op, int sel, logic [DATA_W-1:0] val);
        stack_op_t o;
        o.op  = op;
        o.sel = SEL_W'(sel);
        o.val = val;
        pending_ops.push_back(o);
    endtask

    // driver
    always @(posedge i_clk) begin : drive_ops
        stack_op_t o;
        bit        quiet;
        quiet = pending_ops.size() < 100;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                awaited_results.push_back(run_stack_op(t_op'(s_tuser[0]), s_tuser[3:1], s_tdata));
                n_accepted <= n_accepted + 1;
                if (n_accepted % 128 == 127) begin
                    case ($urandom_range(0, 3))
                        0: idle_pct <= 0;
                        1: idle_pct <= 4;
                        2: idle_pct <= 12;
                        default: idle_pct <= 30;
                    endcase
                end
            end
            if (!s_tvalid || o_s_tready) begin
                if (s_hold != 0) begin
                    s_hold   <= s_hold - 1;
                    s_tvalid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    s_hold   <= $urandom_range(0, 16);
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    o = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= o.val;
                    s_tuser  <= {o.sel, o.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (m_hold != 0) begin
            m_hold   <= m_hold - 1;
            m_tready <= (m_hold == 1);
        end else if (pending_ops.size() >= 100 && $urandom_range(0, 99) < idle_pct) begin
            m_hold   <= $urandom_range(1, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        stack_result_t exp_r;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual success %0d value %h",
                         $time, o_m_tuser[0], o_m_tdata);
                fail_count++;
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_m_tuser[0] !== exp_r.ok) begin
                    $display("%0t: success expected %0d actual %0d",
                             $time, exp_r.ok, o_m_tuser[0]);
                    fail_count++;
                end
                if (o_m_tdata !== exp_r.word) begin
                    $display("%0t: popped_value expected %h actual %h",
                             $time, exp_r.word, o_m_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int  push_pct;
        int  span;
        int  focus;
        bit  single;
        t_op op;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_data[i] = '0;
            pool_link[i] = LNK_W'(i + 1);
        end
        pool_link[POOL_SIZE-1] = LINK_NULL;
        for (int i = 0; i < NUM_STACKS; i++)
            head_of[i] = LINK_NULL;
        free_ptr = '0;

        // extreme values, lifo order, empty stacks
        queue_op(OP_PUSH, 0, 32'h7fff_ffff);
        queue_op(OP_PUSH, 0, 32'h8000_0000);
        queue_op(OP_PUSH, 7, 32'h0000_0000);
        queue_op(OP_PUSH, 7, 32'hffff_ffff);
        queue_op(OP_POP, 0, 32'h0000_0000);
        queue_op(OP_POP, 0, 32'hffff_ffff);
        queue_op(OP_POP, 0, 32'h5555_aaaa);
        queue_op(OP_POP, 7, 32'haaaa_5555);
        queue_op(OP_POP, 7, 32'h0000_0000);
        queue_op(OP_POP, 7, 32'hffff_ffff);
        for (int s = 0; s < NUM_STACKS; s++)
            queue_op(OP_PUSH, s, 32'ha5c3_0000 | s);
        for (int s = 0; s < NUM_STACKS; s++)
            queue_op(OP_POP, s, $urandom);

        // fill past full, then drain past empty
        repeat (68) queue_op(OP_PUSH, $urandom_range(0, NUM_STACKS - 1), pick_value());
        repeat (72) queue_op(OP_POP, $urandom_range(0, NUM_STACKS - 1), $urandom);

        while (pending_ops.size() < 1450) begin
            case ($urandom_range(0, 4))
                0: push_pct = 90;
                1: push_pct = 10;
                2: push_pct = 50;
                3: push_pct = 70;
                default: push_pct = 30;
            endcase
            span   = $urandom_range(40, 150);
            single = ($urandom_range(0, 3) == 0);
            focus  = $urandom_range(0, NUM_STACKS - 1);
            repeat (span) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                queue_op(op, single ? focus : $urandom_range(0, NUM_STACKS - 1),
                         (op == OP_PUSH) ? pick_value() : $urandom);
            end
        end
        total_ops = pending_ops.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != total_ops)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
